// File: sv/g2n_pkg.sv
package g2n_pkg;

    // Pipeline depths
    localparam int MUL_LAT  = 3;
    localparam int STEPS    = 30;
    localparam int SC_LAT   = 6 + STEPS + 1;
    localparam int ECEF_LAT = 6 + 8 * MUL_LAT;
    localparam int NED_LAT  = 2 * MUL_LAT + 2;

    // Sine/cosine word width (Q30 plus headroom)
    localparam int TRIG_W = 34;

    // Ellipsoid constants and rotation gain
    localparam logic signed [63:0] E2_Q40        = 64'sd7360548641;
    localparam logic signed [63:0] SEMI_MAJOR_MM = 64'sd6378137000;
    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 34'sd652032874;

    // Angle scaling: 2^32 / 3.6e9, upper word is one
    localparam logic [29:0] RECIP_LO = 30'd829128280;
    localparam logic [31:0] TURN_DIV = 32'd3600000000;
    localparam logic [31:0] HALF_DIV = 32'd1800000000;

    // Arctangent per rotation step, 2^-32 turn
    localparam logic [31:0] ATAN_TAB [STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    typedef enum logic [1:0] {
        REG_REF_LAT = 2'd0,
        REG_REF_LON = 2'd1,
        REG_REF_ALT = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic signed [30:0] latitude;
        logic signed [31:0] longitude;
        logic signed [27:0] altitude;
    } fix_t;

    typedef struct packed {
        logic signed [35:0] north;
        logic signed [35:0] east;
        logic signed [35:0] down;
    } ned_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } ecef_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sl;
        logic signed [TRIG_W-1:0] cl;
        logic signed [TRIG_W-1:0] sn;
        logic signed [TRIG_W-1:0] cn;
    } trig_t;

    function automatic logic signed [63:0] ext_trig(input logic signed [TRIG_W-1:0] v);
        return {{(64 - TRIG_W){v[TRIG_W-1]}}, v};
    endfunction

    function automatic logic signed [63:0] alt_q16(input logic signed [27:0] a);
        return {{20{a[27]}}, a, 16'h0000};
    endfunction

endpackage

// File: sv/g2n_delay.sv
module g2n_delay
    import g2n_pkg::*;
#(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [D];

    // Shift the word down the line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < D; i++)
            begin
                pipe_reg[i] <= '0;
            end
        end
        else
        begin
            pipe_reg[0] <= d;
            for (int i = 1; i < D; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[D-1];

endmodule

// File: sv/g2n_mul.sv
module g2n_mul
    import g2n_pkg::*;
#(
    parameter int SH = 30
) (
    input  logic               clk,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] y
);

    logic        neg_reg, neg2_reg;
    logic [63:0] ua_reg, ub_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [63:0] ua_next, ub_next;
    logic [127:0] full, shifted;
    logic [63:0]  mag;
    logic signed [63:0] y_next;

    // Take magnitudes
    assign ua_next = a[63] ? (~a + 64'd1) : a;
    assign ub_next = b[63] ? (~b + 64'd1) : b;

    // Round half away from zero, shift, saturate, restore sign
    always_comb
    begin
        full = {64'h0, p00_reg} + {32'h0, p01_reg, 32'h0} + {32'h0, p10_reg, 32'h0}
             + {p11_reg, 64'h0} + (128'd1 << (SH - 1));
        shifted = full >> SH;
        mag = (|shifted[127:63]) ? {1'b0, {63{1'b1}}} : shifted[63:0];
        y_next = neg2_reg ? -$signed(mag) : $signed(mag);
    end

    // Magnitude, partial products, result
    always_ff @(posedge clk)
    begin
        neg_reg  <= a[63] ^ b[63];
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
        neg2_reg <= neg_reg;
        p00_reg  <= ua_reg[31:0] * ub_reg[31:0];
        p01_reg  <= ua_reg[31:0] * ub_reg[63:32];
        p10_reg  <= ua_reg[63:32] * ub_reg[31:0];
        p11_reg  <= ua_reg[63:32] * ub_reg[63:32];
        y        <= y_next;
    end

endmodule

// File: sv/g2n_sincos.sv
module g2n_sincos
    import g2n_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [31:0]       angle,
    output logic                     out_valid,
    output logic signed [TRIG_W-1:0] sine,
    output logic signed [TRIG_W-1:0] cosine
);

    logic [6:1]  v_reg;
    logic [5:1]  neg_reg;
    logic [31:0] mag1_reg, mag2_reg, mag3_reg;
    logic [61:0] prod2_reg;
    logic [32:0] qe3_reg, qe4_reg;
    logic [65:0] qp4_reg;
    logic [63:0] turn4_reg;
    logic [31:0] u5_reg;
    logic [1:0]  quad6_reg;
    logic signed [TRIG_W-1:0] z6_reg;

    logic [61:0] prod2_next;
    logic [65:0] rem5;
    logic [32:0] q5;
    logic [31:0] u5_next, rnd6, z6_raw;
    logic [1:0]  quad6_next;

    logic signed [TRIG_W-1:0] x_reg [STEPS];
    logic signed [TRIG_W-1:0] y_reg [STEPS];
    logic signed [TRIG_W-1:0] z_reg [STEPS];
    logic [1:0]               q_reg [STEPS];
    logic [STEPS-1:0]         cv_reg;
    logic                     out_v_reg;
    logic signed [TRIG_W-1:0] sine_reg, cosine_reg;
    logic signed [TRIG_W-1:0] sine_next, cosine_next;

    // Binary angle: estimate by reciprocal, then correct the remainder
    assign prod2_next = mag1_reg * RECIP_LO;
    always_comb
    begin
        rem5 = {2'b00, turn4_reg} - qp4_reg;
        if (rem5 >= {33'd0, TURN_DIV, 1'b0})
        begin
            q5 = qe4_reg + 33'd2;
        end
        else if (rem5 >= {34'd0, TURN_DIV})
        begin
            q5 = qe4_reg + 33'd1;
        end
        else
        begin
            q5 = qe4_reg;
        end
        u5_next = neg_reg[4] ? (~q5[31:0] + 32'd1) : q5[31:0];
        rnd6 = u5_reg + 32'h2000_0000;
        quad6_next = rnd6[31:30];
        z6_raw = u5_reg - {rnd6[31:30], 30'h0};
    end

    // Valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[5:1], in_valid};
        end
    end

    // Front stages: magnitude, product, estimate, back product, correct, quadrant
    always_ff @(posedge clk)
    begin
        neg_reg   <= {neg_reg[4:1], angle[31]};
        mag1_reg  <= angle[31] ? (~angle + 32'd1) : angle;
        mag2_reg  <= mag1_reg;
        prod2_reg <= prod2_next;
        mag3_reg  <= mag2_reg;
        qe3_reg   <= {1'b0, mag2_reg} + {3'b000, prod2_reg[61:32]};
        qe4_reg   <= qe3_reg;
        qp4_reg   <= qe3_reg * TURN_DIV;
        turn4_reg <= {mag3_reg, 32'h0} + {32'h0, HALF_DIV};
        u5_reg    <= u5_next;
        quad6_reg <= quad6_next;
        z6_reg    <= {{(TRIG_W - 32){z6_raw[31]}}, z6_raw};
    end

    // Rotation steps, one per stage
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [TRIG_W-1:0] xin, yin, zin, ang;
        logic [1:0] qin;
        logic       vin;
        if (i == 0)
        begin : g_first
            assign xin = GAIN_Q30;
            assign yin = '0;
            assign zin = z6_reg;
            assign qin = quad6_reg;
            assign vin = v_reg[6];
        end
        else
        begin : g_next
            assign xin = x_reg[i-1];
            assign yin = y_reg[i-1];
            assign zin = z_reg[i-1];
            assign qin = q_reg[i-1];
            assign vin = cv_reg[i-1];
        end
        assign ang = {{(TRIG_W - 32){1'b0}}, ATAN_TAB[i]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i] <= 1'b0;
            end
            else
            begin
                cv_reg[i] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            q_reg[i] <= qin;
            if (!zin[TRIG_W-1])
            begin
                x_reg[i] <= xin - (yin >>> i);
                y_reg[i] <= yin + (xin >>> i);
                z_reg[i] <= zin - ang;
            end
            else
            begin
                x_reg[i] <= xin + (yin >>> i);
                y_reg[i] <= yin - (xin >>> i);
                z_reg[i] <= zin + ang;
            end
        end
    end

    // Map back to the full turn by quadrant
    always_comb
    begin
        unique case (q_reg[STEPS-1])
            2'd0:
            begin
                cosine_next = x_reg[STEPS-1];
                sine_next   = y_reg[STEPS-1];
            end
            2'd1:
            begin
                cosine_next = -y_reg[STEPS-1];
                sine_next   = x_reg[STEPS-1];
            end
            2'd2:
            begin
                cosine_next = -x_reg[STEPS-1];
                sine_next   = -y_reg[STEPS-1];
            end
            default:
            begin
                cosine_next = y_reg[STEPS-1];
                sine_next   = -x_reg[STEPS-1];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= cv_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sine_reg   <= sine_next;
        cosine_reg <= cosine_next;
    end

    assign out_valid = out_v_reg;
    assign sine      = sine_reg;
    assign cosine    = cosine_reg;

endmodule

// File: sv/g2n_ecef.sv
module g2n_ecef
    import g2n_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  trig_t              trig_in,
    input  logic signed [27:0] alt,
    output logic               out_valid,
    output ecef_t              pos,
    output trig_t              trig_out
);

    localparam int L  = MUL_LAT;
    localparam int TN = 5 + 6 * L;

    localparam logic signed [63:0] G35   = 64'sd35 <<< 53;
    localparam logic signed [63:0] G5    = 64'sd5 <<< 56;
    localparam logic signed [63:0] G3    = 64'sd3 <<< 57;
    localparam logic signed [63:0] G1    = 64'sd1 <<< 59;
    localparam logic signed [63:0] A_Q16 = SEMI_MAJOR_MM <<< 16;

    logic signed [2*TRIG_W-1:0] sq;
    logic signed [63:0] ss_reg, u0, ud1, ud2, ud3, m1, m2, m3, gg, m4;
    logic signed [63:0] g1_reg, g2_reg, g3_reg, n_reg, h_reg, zz_reg;
    logic signed [63:0] ad1, ad2, nd, mz, xc, px, py, pz;
    logic signed [TRIG_W-1:0] cl1, cn2, sn2, sl2;

    assign sq = trig_in.sl * trig_in.sl;

    // Series for the prime-vertical radius
    always_ff @(posedge clk)
    begin
        ss_reg <= sq[63:0];
        g1_reg <= m1 + G5;
        g2_reg <= m2 + G3;
        g3_reg <= m3 + G1;
        n_reg  <= A_Q16 + m4;
        h_reg  <= n_reg + ad1;
        zz_reg <= nd - mz + ad2;
    end

    g2n_mul #(.SH(40)) u_mul_u (.clk(clk), .a(E2_Q40), .b(ss_reg), .y(u0));
    g2n_mul #(.SH(60)) u_mul_g1 (.clk(clk), .a(u0), .b(G35), .y(m1));
    g2n_delay #(.W(64), .D(L + 1)) u_dly_u1 (.clk(clk), .rst_n(rst_n), .d(u0), .q(ud1));
    g2n_mul #(.SH(60)) u_mul_g2 (.clk(clk), .a(ud1), .b(g1_reg), .y(m2));
    g2n_delay #(.W(64), .D(L + 1)) u_dly_u2 (.clk(clk), .rst_n(rst_n), .d(ud1), .q(ud2));
    g2n_mul #(.SH(60)) u_mul_g3 (.clk(clk), .a(ud2), .b(g2_reg), .y(m3));
    g2n_delay #(.W(64), .D(L + 1)) u_dly_u3 (.clk(clk), .rst_n(rst_n), .d(ud2), .q(ud3));
    g2n_mul #(.SH(60)) u_mul_g4 (.clk(clk), .a(ud3), .b(g3_reg), .y(gg));
    g2n_mul #(.SH(44)) u_mul_n (.clk(clk), .a(SEMI_MAJOR_MM), .b(gg), .y(m4));

    // Altitude and polar radius terms
    g2n_delay #(.W(64), .D(TN)) u_dly_a1
        (.clk(clk), .rst_n(rst_n), .d(alt_q16(alt)), .q(ad1));
    g2n_delay #(.W(64), .D(L)) u_dly_a2 (.clk(clk), .rst_n(rst_n), .d(ad1), .q(ad2));
    g2n_delay #(.W(64), .D(L)) u_dly_n (.clk(clk), .rst_n(rst_n), .d(n_reg), .q(nd));
    g2n_mul #(.SH(40)) u_mul_mz (.clk(clk), .a(n_reg), .b(E2_Q40), .y(mz));

    // Project onto the axes
    g2n_delay #(.W(TRIG_W), .D(TN + 1)) u_dly_cl
        (.clk(clk), .rst_n(rst_n), .d(trig_in.cl), .q(cl1));
    g2n_delay #(.W(TRIG_W), .D(TN + 1 + L)) u_dly_cn
        (.clk(clk), .rst_n(rst_n), .d(trig_in.cn), .q(cn2));
    g2n_delay #(.W(TRIG_W), .D(TN + 1 + L)) u_dly_sn
        (.clk(clk), .rst_n(rst_n), .d(trig_in.sn), .q(sn2));
    g2n_delay #(.W(TRIG_W), .D(TN + 1 + L)) u_dly_sl
        (.clk(clk), .rst_n(rst_n), .d(trig_in.sl), .q(sl2));

    g2n_mul #(.SH(30)) u_mul_xc (.clk(clk), .a(h_reg), .b(ext_trig(cl1)), .y(xc));
    g2n_mul #(.SH(30)) u_mul_x (.clk(clk), .a(xc), .b(ext_trig(cn2)), .y(px));
    g2n_mul #(.SH(30)) u_mul_y (.clk(clk), .a(xc), .b(ext_trig(sn2)), .y(py));
    g2n_mul #(.SH(30)) u_mul_z (.clk(clk), .a(zz_reg), .b(ext_trig(sl2)), .y(pz));

    // Carry trig and valid alongside
    g2n_delay #(.W($bits(trig_t)), .D(ECEF_LAT)) u_dly_trig
        (.clk(clk), .rst_n(rst_n), .d(trig_in), .q(trig_out));
    g2n_delay #(.W(1), .D(ECEF_LAT)) u_dly_v
        (.clk(clk), .rst_n(rst_n), .d(in_valid), .q(out_valid));

    assign pos.x = px;
    assign pos.y = py;
    assign pos.z = pz;

endmodule

// File: sv/g2n_ned.sv
module g2n_ned
    import g2n_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  ecef_t fix_pos,
    input  ecef_t ref_pos,
    input  trig_t ref_trig,
    output logic  out_valid,
    output ned_t  ned
);

    localparam int L = MUL_LAT;

    ecef_t d_reg, dd;
    trig_t td;
    logic signed [63:0] f_slcn, f_slsn, f_clcn, f_clsn;
    logic signed [63:0] t1, t2, t3, t4, t5, t6, t7, t8;
    logic signed [63:0] nrt_reg, est_reg, dwn_reg;
    ned_t ned_reg;

    // Round to whole millimetres and saturate
    function automatic logic signed [35:0] finish(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] rnd;
        logic [47:0] r;
        logic signed [35:0] res;
        mag = v[63] ? (~v + 64'd1) : v;
        rnd = mag + 64'd32768;
        r = rnd[63:16];
        if (!v[63])
        begin
            res = (r > 48'h0007_FFFF_FFFF) ? 36'sh7_FFFF_FFFF : r[35:0];
        end
        else
        begin
            res = (r > 48'h0008_0000_0000) ? 36'sh8_0000_0000 : -$signed(r[35:0]);
        end
        return res;
    endfunction

    // Difference and sums
    always_ff @(posedge clk)
    begin
        d_reg.x <= fix_pos.x - ref_pos.x;
        d_reg.y <= fix_pos.y - ref_pos.y;
        d_reg.z <= fix_pos.z - ref_pos.z;
        nrt_reg <= t3 - t1 - t2;
        est_reg <= t5 - t4;
        dwn_reg <= -(t6 + t7 + t8);
        ned_reg.north <= finish(nrt_reg);
        ned_reg.east  <= finish(est_reg);
        ned_reg.down  <= finish(dwn_reg);
    end

    g2n_delay #(.W($bits(ecef_t)), .D(L - 1)) u_dly_d
        (.clk(clk), .rst_n(rst_n), .d(d_reg), .q(dd));
    g2n_delay #(.W($bits(trig_t)), .D(L)) u_dly_t
        (.clk(clk), .rst_n(rst_n), .d(ref_trig), .q(td));

    // Rotation factors
    g2n_mul #(.SH(30)) u_mul_f1
        (.clk(clk), .a(ext_trig(ref_trig.sl)), .b(ext_trig(ref_trig.cn)), .y(f_slcn));
    g2n_mul #(.SH(30)) u_mul_f2
        (.clk(clk), .a(ext_trig(ref_trig.sl)), .b(ext_trig(ref_trig.sn)), .y(f_slsn));
    g2n_mul #(.SH(30)) u_mul_f3
        (.clk(clk), .a(ext_trig(ref_trig.cl)), .b(ext_trig(ref_trig.cn)), .y(f_clcn));
    g2n_mul #(.SH(30)) u_mul_f4
        (.clk(clk), .a(ext_trig(ref_trig.cl)), .b(ext_trig(ref_trig.sn)), .y(f_clsn));

    // Rotated terms
    g2n_mul #(.SH(30)) u_mul_t1 (.clk(clk), .a(dd.x), .b(f_slcn), .y(t1));
    g2n_mul #(.SH(30)) u_mul_t2 (.clk(clk), .a(dd.y), .b(f_slsn), .y(t2));
    g2n_mul #(.SH(30)) u_mul_t3 (.clk(clk), .a(dd.z), .b(ext_trig(td.cl)), .y(t3));
    g2n_mul #(.SH(30)) u_mul_t4 (.clk(clk), .a(dd.x), .b(ext_trig(td.sn)), .y(t4));
    g2n_mul #(.SH(30)) u_mul_t5 (.clk(clk), .a(dd.y), .b(ext_trig(td.cn)), .y(t5));
    g2n_mul #(.SH(30)) u_mul_t6 (.clk(clk), .a(dd.x), .b(f_clcn), .y(t6));
    g2n_mul #(.SH(30)) u_mul_t7 (.clk(clk), .a(dd.y), .b(f_clsn), .y(t7));
    g2n_mul #(.SH(30)) u_mul_t8 (.clk(clk), .a(dd.z), .b(ext_trig(td.sl)), .y(t8));

    g2n_delay #(.W(1), .D(NED_LAT)) u_dly_v
        (.clk(clk), .rst_n(rst_n), .d(in_valid), .q(out_valid));

    assign ned = ned_reg;

endmodule

// File: sv/geodetic_to_local_ned_top.sv
// A fix passes the sine/cosine, earth-centred and rotation stages in that order.
// Throughput: one fix per cycle; busy stays low, start may be high every cycle.
// Each result is shown for one cycle with done; the receiver cannot stall.
// Reset (rst_n low, asynchronous) clears all valid bits and sets the reference to zero.
// The multiplier units (three stages each) set the depth of the earth-centred chain.
module geodetic_to_local_ned_top
    import g2n_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  fix_t        fix,
    output logic        done,
    output ned_t        result,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [31:0] wr_data
);

    logic signed [30:0] ref_lat_reg;
    logic signed [31:0] ref_lon_reg;
    logic signed [27:0] ref_alt_reg;

    logic signed [TRIG_W-1:0] f_sl, f_cl, f_sn, f_cn, r_sl, r_cl, r_sn, r_cn;
    logic  f_lat_v;
    trig_t f_trig, r_trig, r_trig_out;
    logic signed [27:0] f_alt_d, r_alt_d;
    ecef_t f_pos, r_pos;
    logic  f_pos_v;

    // Write reference registers; unknown index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_lat_reg <= '0;
            ref_lon_reg <= '0;
            ref_alt_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_REF_LAT: ref_lat_reg <= wr_data[30:0];
                REG_REF_LON: ref_lon_reg <= wr_data;
                REG_REF_ALT: ref_alt_reg <= wr_data[27:0];
                default:     ref_lat_reg <= ref_lat_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    // Sine and cosine of fix and reference
    g2n_sincos u_sc_flat (.clk(clk), .rst_n(rst_n), .in_valid(start),
        .angle({fix.latitude[30], fix.latitude}), .out_valid(f_lat_v),
        .sine(f_sl), .cosine(f_cl));
    g2n_sincos u_sc_flon (.clk(clk), .rst_n(rst_n), .in_valid(start),
        .angle(fix.longitude), .out_valid(),
        .sine(f_sn), .cosine(f_cn));
    g2n_sincos u_sc_rlat (.clk(clk), .rst_n(rst_n), .in_valid(start),
        .angle({ref_lat_reg[30], ref_lat_reg}), .out_valid(),
        .sine(r_sl), .cosine(r_cl));
    g2n_sincos u_sc_rlon (.clk(clk), .rst_n(rst_n), .in_valid(start),
        .angle(ref_lon_reg), .out_valid(),
        .sine(r_sn), .cosine(r_cn));

    assign f_trig = '{sl: f_sl, cl: f_cl, sn: f_sn, cn: f_cn};
    assign r_trig = '{sl: r_sl, cl: r_cl, sn: r_sn, cn: r_cn};

    // Hold altitudes beside the angle stages
    g2n_delay #(.W(28), .D(SC_LAT)) u_dly_falt
        (.clk(clk), .rst_n(rst_n), .d(fix.altitude), .q(f_alt_d));
    g2n_delay #(.W(28), .D(SC_LAT)) u_dly_ralt
        (.clk(clk), .rst_n(rst_n), .d(ref_alt_reg), .q(r_alt_d));

    // Earth-centred positions
    g2n_ecef u_ecef_fix (.clk(clk), .rst_n(rst_n), .in_valid(f_lat_v),
        .trig_in(f_trig), .alt(f_alt_d), .out_valid(f_pos_v), .pos(f_pos), .trig_out());
    g2n_ecef u_ecef_ref (.clk(clk), .rst_n(rst_n), .in_valid(f_lat_v),
        .trig_in(r_trig), .alt(r_alt_d), .out_valid(), .pos(r_pos), .trig_out(r_trig_out));

    // Rotate into the local frame
    g2n_ned u_ned (.clk(clk), .rst_n(rst_n), .in_valid(f_pos_v), .fix_pos(f_pos),
        .ref_pos(r_pos), .ref_trig(r_trig_out), .out_valid(done), .ned(result));

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import g2n_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    fix_t        fix;
    logic        done;
    ned_t        result;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [31:0] wr_data;

    // Reference point as the converter should hold it
    longint ref_lat;
    longint ref_lon;
    longint ref_alt;

    ned_t   expected_ned[$];
    int     error_count = 0;
    int     fixes_sent;
    int     results_seen = 0;
    int     cfg_writes;
    longint cycle_count = 0;

    geodetic_to_local_ned_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .fix      (fix),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // (a*b) >> sh on the full product, rounded half away from zero
    function automatic longint mul_round(input longint a, input longint b, input int sh);
        logic signed [127:0] sa;
        logic signed [127:0] sb;
        logic [127:0]        ma;
        logic [127:0]        mb;
        logic [127:0]        mag;
        logic                neg;
        sa = a;
        sb = b;
        neg = (a < 0) != (b < 0);
        ma = (sa < 0) ? 128'(-sa) : 128'(sa);
        mb = (sb < 0) ? 128'(-sb) : 128'(sb);
        mag = ((ma * mb) + (128'd1 << (sh - 1))) >> sh;
        if (mag > 128'h7fffffffffffffff)
            mag = 128'h7fffffffffffffff;
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    // Degrees times 1e7 to a binary angle, one turn is 2^32
    function automatic logic [31:0] to_turn(input longint d);
        logic [63:0] m;
        logic [63:0] q;
        m = (d < 0) ? 64'(-d) : 64'(d);
        q = ((m << 32) + 64'd1800000000) / 64'd3600000000;
        if (d < 0)
            q = -q;
        return q[31:0];
    endfunction

    function automatic void sin_cos(input longint d, output longint s, output longint c);
        logic [31:0]        a;
        logic [63:0]        t;
        logic [1:0]         q;
        logic signed [31:0] r;
        longint             x;
        longint             y;
        longint             z;
        longint             tx;
        longint             ty;
        a = to_turn(d);
        t = {32'd0, a} + 64'h20000000;
        q = t[31:30];
        r = a - (32'(q) << 30);
        z = r;
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            tx = y >>> i;
            ty = x >>> i;
            if (z >= 0)
            begin
                x = x - tx;
                y = y + ty;
                z = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + tx;
                y = y - ty;
                z = z + longint'(ATAN_TAB[i]);
            end
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // Earth-centred position in Q16 mm plus the trig terms of the point
    function automatic void to_ecef(input longint lat, input longint lon, input longint alt,
                                    output longint ex, output longint ey, output longint ez,
                                    output longint sl, output longint cl,
                                    output longint sn, output longint cn);
        longint e2;
        longint a_mm;
        longint u;
        longint g;
        longint n;
        longint h;
        e2 = E2_Q40;
        a_mm = SEMI_MAJOR_MM;
        sin_cos(lat, sl, cl);
        sin_cos(lon, sn, cn);
        u = mul_round(e2, sl * sl, 40);
        g = 64'sd35 << 53;
        g = (64'sd5 << 56) + mul_round(u, g, 60);
        g = (64'sd3 << 57) + mul_round(u, g, 60);
        g = (64'sd1 << 59) + mul_round(u, g, 60);
        g = mul_round(u, g, 60);
        n = a_mm * 65536 + mul_round(a_mm, g, 44);
        h = n + alt * 65536;
        ex = mul_round(mul_round(h, cl, 30), cn, 30);
        ey = mul_round(mul_round(h, cl, 30), sn, 30);
        ez = mul_round(n - mul_round(n, e2, 40) + alt * 65536, sl, 30);
    endfunction

    function automatic logic signed [35:0] round_sat_mm(input longint v);
        longint r;
        r = mul_round(v, 1, 16);
        if (r > 64'sd34359738367)
            r = 64'sd34359738367;
        if (r < -64'sd34359738368)
            r = -64'sd34359738368;
        return r[35:0];
    endfunction

    function automatic ned_t ned_predict(input fix_t f);
        longint fx, fy, fz, rx, ry, rz;
        longint fsl, fcl, fsn, fcn;
        longint sl, cl, sn, cn;
        longint dx, dy, dz;
        longint n_q16, e_q16, d_q16;
        ned_t   o;
        to_ecef(f.latitude, f.longitude, f.altitude, fx, fy, fz, fsl, fcl, fsn, fcn);
        to_ecef(ref_lat, ref_lon, ref_alt, rx, ry, rz, sl, cl, sn, cn);
        dx = fx - rx;
        dy = fy - ry;
        dz = fz - rz;
        n_q16 = -mul_round(dx, mul_round(sl, cn, 30), 30)
                - mul_round(dy, mul_round(sl, sn, 30), 30)
                + mul_round(dz, cl, 30);
        e_q16 = -mul_round(dx, sn, 30) + mul_round(dy, cn, 30);
        d_q16 = -(mul_round(dx, mul_round(cl, cn, 30), 30)
                  + mul_round(dy, mul_round(cl, sn, 30), 30)
                  + mul_round(dz, sl, 30));
        o.north = round_sat_mm(n_q16);
        o.east  = round_sat_mm(e_q16);
        o.down  = round_sat_mm(d_q16);
        return o;
    endfunction

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen <= results_seen + 1;
            if (expected_ned.size() == 0)
            begin
                $display("%0t: unexpected result n=%0d e=%0d d=%0d", $time,
                         result.north, result.east, result.down);
                error_count <= error_count + 1;
            end
            else
            begin
                ned_t want;
                want = expected_ned.pop_front();
                if (result.north !== want.north || result.east !== want.east
                    || result.down !== want.down)
                begin
                    $display("%0t: mismatch expected n=%0d e=%0d d=%0d actual n=%0d e=%0d d=%0d",
                             $time, want.north, want.east, want.down,
                             result.north, result.east, result.down);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Pick a gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Hold start until the transfer happens, then idle for the gap if it is not zero
    task automatic send_fix(input fix_t f, input int gap);
        logic was_busy;
        start <= 1'b1;
        fix   <= f;
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
        expected_ned.push_back(ned_predict(f));
        fixes_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start before the next edge, then wait for every result
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_ned.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write a reference register; block must be idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_REF_LAT: ref_lat = longint'($signed(data[30:0]));
            REG_REF_LON: ref_lon = longint'($signed(data[31:0]));
            REG_REF_ALT: ref_alt = longint'($signed(data[27:0]));
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic set_reference(input longint lat, input longint lon, input longint alt);
        write_reg(REG_REF_LAT, 32'(lat));
        write_reg(REG_REF_LON, 32'(lon));
        write_reg(REG_REF_ALT, 32'(alt));
    endtask

    function automatic fix_t make_fix(input longint lat, input longint lon, input longint alt);
        fix_t f;
        f.latitude  = lat[30:0];
        f.longitude = lon[31:0];
        f.altitude  = alt[27:0];
        return f;
    endfunction

    // Random fix: half near the reference, some anywhere, a few raw bit patterns
    function automatic fix_t random_fix();
        int     r;
        longint lat, lon, alt;
        fix_t   f;
        r = $urandom_range(99);
        if (r < 50)
        begin
            lat = ref_lat + longint'($urandom_range(2000000)) - 1000000;
            lon = ref_lon + longint'($urandom_range(2000000)) - 1000000;
            alt = ref_alt + longint'($urandom_range(200000)) - 100000;
            f = make_fix(lat, lon, alt);
        end
        else if (r < 85)
        begin
            lat = longint'($urandom_range(1800000000)) - 900000000;
            lon = longint'($urandom_range(3600000000)) - 1800000000;
            alt = longint'($urandom_range(101000000)) - 1000000;
            f = make_fix(lat, lon, alt);
        end
        else
        begin
            f = make_fix($urandom, $urandom, $urandom);
        end
        return f;
    endfunction

    task automatic test_reset_reference();
        send_fix(make_fix(0, 0, 0), 0);
        send_fix(make_fix(900000000, 0, 0), 0);
        send_fix(make_fix(-900000000, 0, 0), 1);
        send_fix(make_fix(0, 1800000000, 0), 0);
        send_fix(make_fix(0, -1800000000, 0), 0);
        send_fix(make_fix(0, 0, 100000000), 2);
        send_fix(make_fix(0, 0, -1000000), 0);
        send_fix(make_fix(450000000, 900000000, 12345), 0);
        // latitude past the pole and longitude past a half turn
        send_fix(make_fix(1073741823, 2147483647, 134217727), 0);
        send_fix(make_fix(-1073741824, -2147483648, -134217728), 3);
        send_fix(make_fix(0, 1800000001, 0), 0);
        send_fix(make_fix(-899999999, 2700000000, 0), 0);
        send_fix(make_fix(1, -1, 1), 0);
        drain();
    endtask

    task automatic test_reference_extremes();
        set_reference(900000000, 1800000000, 100000000);
        send_fix(make_fix(900000000, 1800000000, 100000000), 0);
        send_fix(make_fix(-900000000, -1800000000, -1000000), 0);
        send_fix(make_fix(899990000, 1799990000, 99990000), 0);
        drain();
        set_reference(-900000000, -1800000000, -1000000);
        send_fix(make_fix(-900000000, -1800000000, -1000000), 0);
        send_fix(make_fix(900000000, 0, 0), 0);
        drain();
        // raw register patterns, and a write to an unused index that must be dropped
        write_reg(REG_REF_LAT, 32'hffffffff);
        write_reg(REG_REF_LON, 32'h80000000);
        write_reg(REG_REF_ALT, 32'h7fffffff);
        write_reg(REG_UNUSED, 32'h12345678);
        send_fix(make_fix(0, 0, 0), 0);
        send_fix(make_fix(-1, -2147483648, 134217727), 0);
        drain();
    endtask

    task automatic test_random_fixes();
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                set_reference(0, 0, 0);
            else
                set_reference(longint'($urandom_range(1800000000)) - 900000000,
                              longint'($urandom_range(3600000000)) - 1800000000,
                              longint'($urandom_range(101000000)) - 1000000);
            for (int k = 0; k < 125; k++)
                send_fix(random_fix(), (phase % 3 == 1) ? 0 : pick_gap());
            drain();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        fix          = '0;
        wr_en        = 1'b0;
        wr_index     = REG_REF_LAT;
        wr_data      = '0;
        ref_lat      = 0;
        ref_lon      = 0;
        ref_alt      = 0;
        fixes_sent   = 0;
        cfg_writes   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_reference();
        test_reference_extremes();
        test_random_fixes();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d fixes converted, %0d results checked, %0d reference writes",
                 fixes_sent, results_seen, cfg_writes);
        $display("tb: covered poles, date line, wrapped angles and random reference points");
        if (error_count == 0 && expected_ned.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
sv/g2n_pkg.sv
sv/g2n_delay.sv
sv/g2n_mul.sv
sv/g2n_sincos.sv
sv/g2n_ecef.sv
sv/g2n_ned.sv
sv/geodetic_to_local_ned_top.sv
dv/tb.sv
